// ===== hw/rtl/cfa_pkg.sv =====
package cfa_pkg;

    localparam int MAX_FRAMES = 16384;
    localparam int FPW        = 32;
    localparam int WORDS      = MAX_FRAMES / FPW;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = FRAME_W + 1;
    localparam int WADDR_W    = $clog2(WORDS);
    localparam int LANE_W     = $clog2(FPW);
    localparam int WORD_W     = 2 * FPW;
    localparam int ABS_W      = 20;
    localparam int SIZE_W     = 15;
    localparam int CFG_W      = 20;

    localparam logic [1:0] FS_FREE = 2'b00;
    localparam logic [1:0] FS_USED = 2'b01;
    localparam logic [1:0] FS_HEAD = 2'b11;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_MARK    = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_RUN    = 3'd1;
    localparam logic [2:0] ST_TOO_FEW   = 3'd2;
    localparam logic [2:0] ST_BAD_COUNT = 3'd3;
    localparam logic [2:0] ST_OUTSIDE   = 3'd4;
    localparam logic [2:0] ST_NOT_HEAD  = 3'd5;

    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_POOL_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ABS_W-1:0]  frame_no;
        logic [SIZE_W-1:0] count;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [ABS_W-1:0]  result_frame;
        logic [SIZE_W-1:0] free_frames;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_CLAIM,
        S_RELEASE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        WM_SCAN,
        WM_CHECK,
        WM_CLAIM,
        WM_RELEASE
    } t_wmode;

    typedef struct packed {
        t_wmode             mode;
        logic               first;
        logic [WADDR_W-1:0] cur;
        logic [FRAME_W-1:0] lo;
        logic [FRAME_W-1:0] hi;
        logic [CNT_W-1:0]   cnt;
        logic [CNT_W-1:0]   size;
        logic [CNT_W-1:0]   run;
    } t_wctl;

    typedef struct packed {
        logic              hit;
        logic [LANE_W-1:0] hit_lane;
        logic [CNT_W-1:0]  run_out;
        logic              busy_any;
        logic              head_ok;
        logic              stop_found;
        logic [LANE_W:0]   n_cleared;
        logic [WORD_W-1:0] wdata;
    } t_wres;

endpackage

// ===== hw/rtl/cfa_ram.sv =====
module cfa_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cfa_word.sv =====
module cfa_word (
    input  cfa_pkg::t_wctl             i_ctl,
    input  logic [cfa_pkg::WORD_W-1:0] i_rdata,
    output cfa_pkg::t_wres             o_res
);
    import cfa_pkg::*;

    logic [FPW-1:0] in_pool;
    logic [FPW-1:0] free_v;
    logic [FPW-1:0] ge_lo;
    logic [FPW-1:0] gt_lo;
    logic [FPW-1:0] le_hi;
    logic [FPW-1:0] eq_lo;
    logic [LANE_W:0] stop_pos;
    logic [LANE_W-1:0] start_lane;

    always_comb begin
        logic [FRAME_W-1:0] g;
        for (int j = 0; j < FPW; j++) begin
            g = {i_ctl.cur, LANE_W'(j)};
            in_pool[j] = CNT_W'(g) < i_ctl.size;
            free_v[j]  = in_pool[j] && (i_rdata[2*j +: 2] == FS_FREE);
            ge_lo[j]   = g >= i_ctl.lo;
            gt_lo[j]   = g > i_ctl.lo;
            le_hi[j]   = g <= i_ctl.hi;
            eq_lo[j]   = g == i_ctl.lo;
        end
    end

    always_comb begin
        logic [CNT_W:0]    run_j;
        logic [CNT_W:0]    run_last;
        logic              seen;
        logic [LANE_W-1:0] p;
        o_res.hit      = 1'b0;
        o_res.hit_lane = '0;
        run_last       = '0;
        for (int j = 0; j < FPW; j++) begin
            seen = 1'b0;
            p    = '0;
            for (int k = 0; k < FPW; k++) begin
                if (k <= j && !free_v[k]) begin
                    seen = 1'b1;
                    p    = LANE_W'(k);
                end
            end
            if (seen) begin
                run_j = (CNT_W+1)'(j) - (CNT_W+1)'(p);
            end else begin
                run_j = {1'b0, i_ctl.run} + (CNT_W+1)'(j + 1);
            end
            if (!o_res.hit && run_j >= {1'b0, i_ctl.cnt}) begin
                o_res.hit      = 1'b1;
                o_res.hit_lane = LANE_W'(j);
            end
            if (j == FPW - 1) begin
                run_last = run_j;
            end
        end
        o_res.run_out = run_last[CNT_W-1:0];
    end

    always_comb begin
        o_res.busy_any   = 1'b0;
        o_res.head_ok    = 1'b0;
        o_res.stop_found = 1'b0;
        stop_pos         = (LANE_W+1)'(FPW);
        for (int j = 0; j < FPW; j++) begin
            if (ge_lo[j] && le_hi[j] && i_rdata[2*j +: 2] != FS_FREE) begin
                o_res.busy_any = 1'b1;
            end
            if (LANE_W'(j) == i_ctl.lo[LANE_W-1:0]) begin
                o_res.head_ok = i_rdata[2*j +: 2] == FS_HEAD;
            end
        end
        for (int j = FPW - 1; j >= 0; j--) begin
            if (gt_lo[j] && (!in_pool[j] || i_rdata[2*j +: 2] != FS_USED)) begin
                o_res.stop_found = 1'b1;
                stop_pos         = (LANE_W+1)'(j);
            end
        end
        start_lane      = i_ctl.first ? i_ctl.lo[LANE_W-1:0] : '0;
        o_res.n_cleared = stop_pos - {1'b0, start_lane};
    end

    always_comb begin
        o_res.wdata = i_rdata;
        for (int j = 0; j < FPW; j++) begin
            case (i_ctl.mode)
                WM_CLAIM: begin
                    if (eq_lo[j]) begin
                        o_res.wdata[2*j +: 2] = FS_HEAD;
                    end else if (gt_lo[j] && le_hi[j]) begin
                        o_res.wdata[2*j +: 2] = FS_USED;
                    end
                end
                WM_RELEASE: begin
                    if (ge_lo[j] && (LANE_W+1)'(j) < stop_pos) begin
                        o_res.wdata[2*j +: 2] = FS_FREE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/cfa_ctrl.sv =====
module cfa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  cfa_pkg::t_req               i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output cfa_pkg::t_rsp               o_rsp,
    input  logic [cfa_pkg::ABS_W-1:0]   i_pool_base,
    input  logic [cfa_pkg::CNT_W-1:0]   i_size,
    output logic                        o_ram_we,
    output logic [cfa_pkg::WADDR_W-1:0] o_ram_waddr,
    output logic [cfa_pkg::WORD_W-1:0]  o_ram_wdata,
    output logic [cfa_pkg::WADDR_W-1:0] o_ram_raddr,
    input  logic [cfa_pkg::WORD_W-1:0]  i_ram_rdata
);
    import cfa_pkg::*;

    t_state             r_state, n_state;
    logic [WADDR_W-1:0] r_cur, n_cur;
    logic [WADDR_W-1:0] r_last, n_last;
    logic [FRAME_W-1:0] r_lo, n_lo;
    logic [FRAME_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_run, n_run;
    logic [CNT_W-1:0]   r_freed, n_freed;
    logic [CNT_W-1:0]   r_taken, n_taken;
    logic               r_first, n_first;
    logic [2:0]         r_status, n_status;
    logic [ABS_W-1:0]   r_result, n_result;
    logic               r_rsp_valid, n_rsp_valid;
    t_rsp               r_rsp, n_rsp;

    t_wctl wctl;
    t_wres wres;

    logic               accept;
    logic [ABS_W:0]     diff;
    logic               below;
    logic [CNT_W-1:0]   req_cnt;
    logic [CNT_W-1:0]   free_left;
    logic               rel_outside;
    logic               mark_outside;
    logic [FRAME_W-1:0] rel;
    logic [FRAME_W-1:0] end_f;
    logic [FRAME_W-1:0] start_f;
    logic [CNT_W-1:0]   freed_sum;
    logic               head_bad;
    logic               walk_end;
    logic               rsp_load;

    cfa_word u_word (
        .i_ctl   (wctl),
        .i_rdata (i_ram_rdata),
        .o_res   (wres)
    );

    assign accept       = i_req_valid && o_req_ready;
    assign diff         = {1'b0, i_req.frame_no} - {1'b0, i_pool_base};
    assign below        = diff[ABS_W];
    assign req_cnt      = CNT_W'(i_req.count);
    assign free_left    = (i_size > r_taken) ? i_size - r_taken : '0;
    assign rel_outside  = below || (diff[ABS_W-1:0] >= ABS_W'(i_size));
    assign mark_outside = below ||
                          ({1'b0, diff[ABS_W-1:0]} + (ABS_W+1)'(req_cnt) >
                           (ABS_W+1)'(i_size));
    assign rel          = diff[FRAME_W-1:0];
    assign end_f        = {r_cur, wres.hit_lane};
    assign start_f      = end_f - FRAME_W'(r_cnt - 1'b1);
    assign freed_sum    = r_freed + CNT_W'(wres.n_cleared);
    assign head_bad     = r_first && !wres.head_ok;
    assign walk_end     = wres.stop_found || (r_cur == WADDR_W'(WORDS - 1));
    assign rsp_load     = (r_state == S_DONE) && (!r_rsp_valid || i_rsp_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_cur == WADDR_W'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DONE;
                    case (i_req.operation)
                        OP_ALLOC: begin
                            if (req_cnt != '0 && req_cnt <= i_size && req_cnt <= free_left) begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_RELEASE: begin
                            if (!rel_outside) begin
                                n_state = S_RELEASE;
                            end
                        end
                        OP_MARK: begin
                            if (req_cnt != '0 && !mark_outside) begin
                                n_state = S_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (wres.hit) begin
                    n_state = S_CLAIM;
                end else if (r_cur == r_last) begin
                    n_state = S_DONE;
                end
            end
            S_CHECK: begin
                if (wres.busy_any) begin
                    n_state = S_DONE;
                end else if (r_cur == r_last) begin
                    n_state = S_CLAIM;
                end
            end
            S_CLAIM: begin
                if (r_cur == r_last) begin
                    n_state = S_DONE;
                end
            end
            S_RELEASE: begin
                if (head_bad || walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (rsp_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cur       = r_cur;
        n_last      = r_last;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_cnt       = r_cnt;
        n_run       = r_run;
        n_freed     = r_freed;
        n_taken     = r_taken;
        n_first     = r_first;
        n_status    = r_status;
        n_result    = r_result;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                n_cur = r_cur + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_result = '0;
                    n_cnt    = req_cnt;
                    n_run    = '0;
                    n_freed  = '0;
                    n_first  = 1'b1;
                    case (i_req.operation)
                        OP_ALLOC: begin
                            n_cur  = '0;
                            n_last = WADDR_W'((i_size - 1'b1) >> LANE_W);
                            if (req_cnt == '0 || req_cnt > i_size) begin
                                n_status = ST_BAD_COUNT;
                            end else if (req_cnt > free_left) begin
                                n_status = ST_TOO_FEW;
                            end
                        end
                        OP_RELEASE: begin
                            n_lo  = rel;
                            n_cur = rel[FRAME_W-1:LANE_W];
                            if (rel_outside) begin
                                n_status = ST_OUTSIDE;
                            end
                        end
                        OP_MARK: begin
                            n_lo     = rel;
                            n_hi     = rel + FRAME_W'(req_cnt - 1'b1);
                            n_cur    = rel[FRAME_W-1:LANE_W];
                            n_last   = n_hi[FRAME_W-1:LANE_W];
                            n_result = i_req.frame_no;
                            if (req_cnt == '0) begin
                                n_status = ST_BAD_COUNT;
                                n_result = '0;
                            end else if (mark_outside) begin
                                n_status = ST_OUTSIDE;
                                n_result = '0;
                            end
                        end
                        default: begin
                            n_status = ST_BAD_COUNT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (wres.hit) begin
                    n_lo     = start_f;
                    n_hi     = end_f;
                    n_cur    = start_f[FRAME_W-1:LANE_W];
                    n_last   = r_cur;
                    n_result = i_pool_base + ABS_W'(start_f);
                end else if (r_cur == r_last) begin
                    n_status = ST_NO_RUN;
                end else begin
                    n_cur = r_cur + 1'b1;
                    n_run = wres.run_out;
                end
            end
            S_CHECK: begin
                if (wres.busy_any) begin
                    n_status = ST_NO_RUN;
                    n_result = '0;
                end else if (r_cur == r_last) begin
                    n_cur = r_lo[FRAME_W-1:LANE_W];
                end else begin
                    n_cur = r_cur + 1'b1;
                end
            end
            S_CLAIM: begin
                if (r_cur == r_last) begin
                    n_taken = r_taken + r_cnt;
                end else begin
                    n_cur = r_cur + 1'b1;
                end
            end
            S_RELEASE: begin
                if (head_bad) begin
                    n_status = ST_NOT_HEAD;
                end else if (walk_end) begin
                    n_taken = (r_taken > freed_sum) ? r_taken - freed_sum : '0;
                end else begin
                    n_freed = freed_sum;
                    n_cur   = r_cur + 1'b1;
                    n_first = 1'b0;
                end
            end
            S_DONE: begin
                if (rsp_load) begin
                    n_rsp_valid        = 1'b1;
                    n_rsp.status       = r_status;
                    n_rsp.result_frame = r_result;
                    n_rsp.free_frames  = SIZE_W'(free_left);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        wctl.first = r_first;
        wctl.cur   = r_cur;
        wctl.lo    = r_lo;
        wctl.hi    = r_hi;
        wctl.cnt   = r_cnt;
        wctl.size  = i_size;
        wctl.run   = r_run;
        unique case (r_state)
            S_CHECK:   wctl.mode = WM_CHECK;
            S_CLAIM:   wctl.mode = WM_CLAIM;
            S_RELEASE: wctl.mode = WM_RELEASE;
            default:   wctl.mode = WM_SCAN;
        endcase
        o_req_ready = r_state == S_IDLE;
        o_ram_we    = (r_state == S_CLEAR) || (r_state == S_CLAIM) ||
                      ((r_state == S_RELEASE) && !head_bad);
        o_ram_waddr = r_cur;
        o_ram_wdata = (r_state == S_CLEAR) ? '0 : wres.wdata;
        o_ram_raddr = n_cur;
        o_rsp_valid = r_rsp_valid;
        o_rsp       = r_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= '0;
            r_taken     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_taken     <= n_taken;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_cnt    <= n_cnt;
        r_run    <= n_run;
        r_freed  <= n_freed;
        r_first  <= n_first;
        r_status <= n_status;
        r_result <= n_result;
        r_rsp    <= n_rsp;
    end

endmodule

// ===== hw/rtl/contiguous_frame_allocator.sv =====
// Requests are served one at a time; the response is registered after a walk over the 64-bit
// words of frame state that the request visits: allocate scans up to 512 words and then rewrites
// the words its run spans, release walks the words of the sequence, and mark checks and then
// rewrites its words, each word read in turn through the single read port of the state memory.
// After reset a clearing pass writes all 512 state words to free, with ready low;
// configuration writes are taken during it.
module contiguous_frame_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  cfa_pkg::t_req             i_req,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output cfa_pkg::t_rsp             o_rsp,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [cfa_pkg::CFG_W-1:0] i_cfg_data
);
    import cfa_pkg::*;

    logic [ABS_W-1:0]   r_pool_base;
    logic [SIZE_W-1:0]  r_pool_size;
    logic [CNT_W-1:0]   size_eff;
    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [WADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
            r_pool_size <= SIZE_W'(MAX_FRAMES);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POOL_BASE: r_pool_base <= i_cfg_data[ABS_W-1:0];
                CFG_POOL_SIZE: r_pool_size <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign size_eff = (CNT_W'(r_pool_size) > CNT_W'(MAX_FRAMES)) ?
                      CNT_W'(MAX_FRAMES) : CNT_W'(r_pool_size);

    cfa_ram #(
        .DEPTH (WORDS),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_pool_base (r_pool_base),
        .i_size      (size_eff),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    a_no_write_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !o_req_ready)
        else $error("state memory written while a request can be accepted");

    a_free_within_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (CNT_W'(o_rsp.free_frames) <= size_eff))
        else $error("free frame count exceeds pool size");

    a_fail_has_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ST_OK) |-> (o_rsp.result_frame == '0))
        else $error("failed request returned a frame number");

endmodule

// ===== verif/contiguous_frame_allocator_test.sv =====
module contiguous_frame_allocator_test;
    import cfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int LONG_HOLD      = 3000;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    class alloc_scoreboard;
        logic [1:0]  frame_map [MAX_FRAMES];
        int unsigned taken;
        int unsigned base;
        int unsigned psize;
        t_rsp        expected_q [$];
        int          mismatches;
        int          checked;

        function new();
            foreach (frame_map[i]) frame_map[i] = FS_FREE;
            taken      = 0;
            base       = 0;
            psize      = MAX_FRAMES;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_POOL_BASE) begin
                base = value[ABS_W-1:0];
            end else begin
                psize = value[SIZE_W-1:0];
            end
        endfunction

        function int unsigned span();
            return (psize < MAX_FRAMES) ? psize : MAX_FRAMES;
        endfunction

        function int unsigned free_left();
            return (taken < span()) ? span() - taken : 0;
        endfunction

        function void claim(int unsigned start, int unsigned n);
            frame_map[start] = FS_HEAD;
            for (int unsigned i = 1; i < n; i++) frame_map[start + i] = FS_USED;
            taken += n;
        endfunction

        function t_rsp note_request(t_req r);
            t_rsp        rsp;
            int unsigned size;
            int unsigned cnt;
            int unsigned fno;
            int unsigned run;
            int unsigned rel;
            int unsigned freed;
            int unsigned i;
            bit          found;
            size = span();
            cnt  = r.count;
            fno  = r.frame_no;
            rsp.status       = ST_OK;
            rsp.result_frame = '0;
            if (r.operation == OP_ALLOC) begin
                if (cnt == 0 || cnt > size) begin
                    rsp.status = ST_BAD_COUNT;
                end else if (cnt > free_left()) begin
                    rsp.status = ST_TOO_FEW;
                end else begin
                    run   = 0;
                    found = 0;
                    for (i = 0; i < size; i++) begin
                        if (frame_map[i] == FS_FREE) begin
                            run++;
                            if (run == cnt) begin
                                found = 1;
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                    if (found) begin
                        claim(i + 1 - cnt, cnt);
                        rsp.result_frame = ABS_W'(base + i + 1 - cnt);
                    end else begin
                        rsp.status = ST_NO_RUN;
                    end
                end
            end else if (r.operation == OP_RELEASE) begin
                if (fno < base || longint'(fno) >= longint'(base) + size) begin
                    rsp.status = ST_OUTSIDE;
                end else begin
                    rel = fno - base;
                    if (frame_map[rel] != FS_HEAD) begin
                        rsp.status = ST_NOT_HEAD;
                    end else begin
                        freed = 1;
                        frame_map[rel] = FS_FREE;
                        for (i = rel + 1; i < size && frame_map[i] == FS_USED; i++) begin
                            frame_map[i] = FS_FREE;
                            freed++;
                        end
                        taken = (taken > freed) ? taken - freed : 0;
                    end
                end
            end else if (r.operation == OP_MARK) begin
                if (cnt == 0) begin
                    rsp.status = ST_BAD_COUNT;
                end else if (fno < base ||
                             longint'(fno) + cnt > longint'(base) + size) begin
                    rsp.status = ST_OUTSIDE;
                end else begin
                    rel   = fno - base;
                    found = 1;
                    for (i = 0; i < cnt; i++) begin
                        if (frame_map[rel + i] != FS_FREE) begin
                            found = 0;
                            break;
                        end
                    end
                    if (found) begin
                        claim(rel, cnt);
                        rsp.result_frame = ABS_W'(fno);
                    end else begin
                        rsp.status = ST_NO_RUN;
                    end
                end
            end else begin
                rsp.status = ST_BAD_COUNT;
            end
            rsp.free_frames = SIZE_W'(free_left());
            expected_q.push_back(rsp);
            return rsp;
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status %0d frame %0h free %0d",
                             got.status, got.result_frame, got.free_frames);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.status !== want.status || got.result_frame !== want.result_frame ||
                got.free_frames !== want.free_frames) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d frame %0h free %0d, got %0d %0h %0d",
                             want.status, want.result_frame, want.free_frames,
                             got.status, got.result_frame, got.free_frames);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_req_valid;
    logic             o_req_ready;
    t_req             i_req;
    logic             o_rsp_valid;
    logic             i_rsp_ready;
    t_rsp             o_rsp;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    alloc_scoreboard  sb;
    int unsigned      heads [$];
    bit               idle_on;
    bit               hold_request;
    int unsigned      stall_left;
    int unsigned      quiet_cycles;

    contiguous_frame_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        sb           = new();
        idle_on      = 1'b1;
        hold_request = 1'b0;
        stall_left   = 0;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_rsp_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_POOL_BASE;
        i_cfg_data  <= '0;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (o_rsp_valid && i_rsp_ready) sb.check_response(o_rsp);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_rsp_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d responses outstanding",
                         sb.expected_q.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send(logic [1:0] op, int unsigned fno, int unsigned cnt);
        t_req r;
        t_rsp rsp;
        r.operation = op;
        r.frame_no  = fno[ABS_W-1:0];
        r.count     = cnt[SIZE_W-1:0];
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        rsp = sb.note_request(r);
        if (rsp.status == ST_OK && op != OP_RELEASE) heads.push_back(rsp.result_frame);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_pool(int unsigned base, int unsigned size);
        drain();
        repeat (5) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_POOL_BASE;
        i_cfg_data <= CFG_W'(base);
        @(posedge i_clk);
        sb.write_reg(CFG_POOL_BASE, CFG_W'(base));
        i_cfg_idx  <= CFG_POOL_SIZE;
        i_cfg_data <= CFG_W'(size);
        @(posedge i_clk);
        sb.write_reg(CFG_POOL_SIZE, CFG_W'(size));
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request();
        int unsigned sel;
        int unsigned b;
        int unsigned s;
        int unsigned idx;
        b   = sb.base;
        s   = sb.span();
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            if ($urandom_range(0, 9) != 0)
                send(OP_ALLOC, $urandom, $urandom_range(1, (s < 8) ? ((s == 0) ? 1 : s) : 8));
            else
                send(OP_ALLOC, $urandom, $urandom_range(0, 32767));
        end else if (sel < 75) begin
            if (heads.size() != 0 && $urandom_range(0, 99) < 85) begin
                idx = $urandom_range(0, heads.size() - 1);
                send(OP_RELEASE, heads[idx], $urandom);
                heads.delete(idx);
            end else if ($urandom_range(0, 1)) begin
                send(OP_RELEASE, b + $urandom_range(0, s), $urandom);
            end else begin
                send(OP_RELEASE, $urandom, $urandom);
            end
        end else if (sel < 93) begin
            if ($urandom_range(0, 4) != 0)
                send(OP_MARK, b + $urandom_range(0, (s == 0) ? 0 : s - 1), $urandom_range(0, 6));
            else
                send(OP_MARK, $urandom, $urandom);
        end else begin
            send(OP_UNKNOWN, $urandom, $urandom);
        end
    endtask

    task automatic random_phase(int unsigned base, int unsigned size, int n);
        set_pool(base, size);
        for (int k = 0; k < n; k++) random_request();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_pool(100, 64);
        send(OP_ALLOC, 0, 0);
        send(OP_ALLOC, 20'hFFFFF, 65);
        send(OP_ALLOC, 0, 15'h7FFF);
        send(OP_ALLOC, 0, 64);
        send(OP_ALLOC, 0, 1);
        send(OP_RELEASE, 100, 0);
        send(OP_ALLOC, 0, 10);
        send(OP_RELEASE, 99, 0);
        send(OP_RELEASE, 164, 0);
        send(OP_RELEASE, 101, 0);
        send(OP_RELEASE, 20'hFFFFF, 15'h7FFF);
        send(OP_MARK, 110, 5);
        send(OP_MARK, 160, 5);
        send(OP_MARK, 99, 1);
        send(OP_MARK, 112, 2);
        send(OP_MARK, 120, 0);
        send(OP_MARK, 20'hFFFFF, 15'h7FFF);
        send(OP_ALLOC, 0, 6);
        send(OP_RELEASE, 100, 0);
        send(OP_ALLOC, 0, 44);
        send(OP_MARK, 150, 14);
        send(OP_RELEASE, 150, 0);
        send(OP_UNKNOWN, 20'hFFFFF, 15'h7FFF);
        heads.delete();

        random_phase(0, MAX_FRAMES, 40);
        drain();
        random_phase(0, MAX_FRAMES, 30);
        send(OP_ALLOC, 0, MAX_FRAMES);
        send(OP_MARK, 0, MAX_FRAMES);
        random_phase(20'hFFFFF - 23, 40, 50);
        hold_request = 1'b1;
        random_phase(20'hFFFFF - 23, 40, 50);
        random_phase($urandom_range(0, 20'hFFFFF), 1, 40);
        random_phase($urandom_range(0, 20'hFFFFF), 15'h7FFF, 60);
        random_phase(0, 0, 10);
        idle_on = 1'b0;
        random_phase($urandom_range(0, 1000), 200, 80);
        drain();
        repeat (1100) @(posedge i_clk);

        $display("Covered %0d responses over seven pool settings, including a wrapped base,",
                 sb.checked);
        $display("single-frame and full-size pools, a long response stall and a drain.");
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== contiguous_frame_allocator.f =====
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_ram.sv
hw/rtl/cfa_word.sv
hw/rtl/cfa_ctrl.sv
hw/rtl/contiguous_frame_allocator.sv
verif/contiguous_frame_allocator_test.sv
